FILE: rtl/complex_arithmetic_unit_defines.svh
// Assertion helpers used by the RTL output stage (cau_back).
`ifndef COMPLEX_ARITHMETIC_UNIT_DEFINES_SVH
`define COMPLEX_ARITHMETIC_UNIT_DEFINES_SVH
`ifndef SYNTHESIS
`define CAU_ASSERT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define CAU_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);
`define CAU_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);
`else
`define CAU_ASSERT(lbl, clk, rst_n, prop, msg)
`define CAU_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg)
`define CAU_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)
`endif
`endif

FILE: rtl/cau_pkg.sv
package cau_pkg;

	localparam int DATA_WIDTH_DEF = 16;
	localparam int FRAC_BITS_DEF  = 8;

	typedef enum logic [1:0] {
		OP_ADD = 2'd0,
		OP_SUB = 2'd1,
		OP_MUL = 2'd2,
		OP_DIV = 2'd3
	} cau_op_t;

	localparam logic [1:0] ST_OK      = 2'd0;
	localparam logic [1:0] ST_DIVZERO = 2'd1;
	localparam logic [1:0] ST_SAT     = 2'd2;

	// per-request control carried down the divider pipe
	typedef struct packed {
		logic is_div;
		logic div_zero;
		logic neg_re;
		logic neg_im;
		logic ovf_re;
		logic ovf_im;
		logic val_sat;
	} cau_flags_t;

endpackage

FILE: rtl/cau_req_if.sv
interface cau_req_if #(
	parameter int DATA_WIDTH = cau_pkg::DATA_WIDTH_DEF
);
	logic                         valid;
	logic                         ready;
	logic [1:0]                   req_type;
	logic signed [DATA_WIDTH-1:0] a_re;
	logic signed [DATA_WIDTH-1:0] a_im;
	logic signed [DATA_WIDTH-1:0] b_re;
	logic signed [DATA_WIDTH-1:0] b_im;

	modport source (output valid, req_type, a_re, a_im, b_re, b_im, input ready);
	modport sink   (input valid, req_type, a_re, a_im, b_re, b_im, output ready);
endinterface

FILE: rtl/cau_res_if.sv
interface cau_res_if #(
	parameter int DATA_WIDTH = cau_pkg::DATA_WIDTH_DEF
);
	logic                         valid;
	logic                         ready;
	logic signed [DATA_WIDTH-1:0] res_re;
	logic signed [DATA_WIDTH-1:0] res_im;
	logic [1:0]                   status;

	modport source (output valid, res_re, res_im, status, input ready);
	modport sink   (input valid, res_re, res_im, status, output ready);
endinterface

FILE: rtl/cau_front.sv
// Front end: products, sums, rounding and divider setup over three stages.
module cau_front #(
	parameter int DATA_WIDTH = cau_pkg::DATA_WIDTH_DEF,
	parameter int FRAC_BITS  = cau_pkg::FRAC_BITS_DEF,
	parameter int REM_WIDTH  = 3 * DATA_WIDTH + FRAC_BITS + 2
) (
	input  logic                         clk,
	input  logic                         arst_n,
	cau_req_if.sink                      req,
	output logic                         out_valid,
	input  logic                         out_ready,
	output cau_pkg::cau_flags_t          out_flags,
	output logic signed [DATA_WIDTH-1:0] out_val_re,
	output logic signed [DATA_WIDTH-1:0] out_val_im,
	output logic [REM_WIDTH-1:0]         out_rem_re,
	output logic [REM_WIDTH-1:0]         out_rem_im,
	output logic [REM_WIDTH-1:0]         out_dd
);
	localparam int W  = DATA_WIDTH;
	localparam int PW = 2 * W;
	localparam int MW = 2 * W;

	localparam logic [MW-1:0] HI_M  = {{(MW - W + 1){1'b0}}, {(W - 1){1'b1}}};
	localparam logic [MW-1:0] LIM_M = {{(MW - W){1'b0}}, 1'b1, {(W - 1){1'b0}}};
	localparam logic [W-1:0]  MAXV  = {1'b0, {(W - 1){1'b1}}};
	localparam logic [W-1:0]  MINV  = {1'b1, {(W - 1){1'b0}}};

	// stage 1
	logic                   v_s1;
	cau_pkg::cau_op_t       op_s1;
	logic                   bz_s1;
	logic signed [PW-1:0]   p_rr_s1, p_ii_s1, p_ri_s1, p_ir_s1, p_br_s1, p_bi_s1;
	logic signed [W:0]      sum_re_s1, sum_im_s1;
	// stage 2
	logic                   v_s2;
	cau_pkg::cau_op_t       op_s2;
	logic                   bz_s2;
	logic signed [PW:0]     t_re_s2, t_im_s2;
	logic [PW-1:0]          den_s2;
	logic signed [W:0]      sum_re_s2, sum_im_s2;
	// stage 3
	logic                   v_s3;

	logic rdy1, rdy2, rdy3;
	assign rdy3      = !v_s3 || out_ready;
	assign rdy2      = !v_s2 || rdy3;
	assign rdy1      = !v_s1 || rdy2;
	assign req.ready = rdy1;
	assign out_valid = v_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			if (rdy1) v_s1 <= req.valid;
			if (rdy2) v_s2 <= v_s1;
			if (rdy3) v_s3 <= v_s2;
		end
	end

	cau_pkg::cau_op_t  op_in;
	logic signed [W:0] ar_x, ai_x, br_x, bi_x;
	assign op_in = cau_pkg::cau_op_t'(req.req_type);
	assign ar_x  = $signed({req.a_re[W-1], req.a_re});
	assign ai_x  = $signed({req.a_im[W-1], req.a_im});
	assign br_x  = $signed({req.b_re[W-1], req.b_re});
	assign bi_x  = $signed({req.b_im[W-1], req.b_im});

	always_ff @(posedge clk) begin
		if (rdy1 && req.valid) begin
			op_s1     <= op_in;
			bz_s1     <= (req.b_re == '0) && (req.b_im == '0);
			p_rr_s1   <= PW'(req.a_re) * PW'(req.b_re);
			p_ii_s1   <= PW'(req.a_im) * PW'(req.b_im);
			p_ri_s1   <= PW'(req.a_re) * PW'(req.b_im);
			p_ir_s1   <= PW'(req.a_im) * PW'(req.b_re);
			p_br_s1   <= PW'(req.b_re) * PW'(req.b_re);
			p_bi_s1   <= PW'(req.b_im) * PW'(req.b_im);
			sum_re_s1 <= (op_in == cau_pkg::OP_SUB) ? ar_x - br_x : ar_x + br_x;
			sum_im_s1 <= (op_in == cau_pkg::OP_SUB) ? ai_x - bi_x : ai_x + bi_x;
		end
	end

	logic signed [PW:0] rr_x, ii_x, ri_x, ir_x;
	assign rr_x = $signed({p_rr_s1[PW-1], p_rr_s1});
	assign ii_x = $signed({p_ii_s1[PW-1], p_ii_s1});
	assign ri_x = $signed({p_ri_s1[PW-1], p_ri_s1});
	assign ir_x = $signed({p_ir_s1[PW-1], p_ir_s1});

	always_ff @(posedge clk) begin
		if (rdy2 && v_s1) begin
			op_s2     <= op_s1;
			bz_s2     <= bz_s1;
			sum_re_s2 <= sum_re_s1;
			sum_im_s2 <= sum_im_s1;
			den_s2    <= $unsigned(p_br_s1) + $unsigned(p_bi_s1);
			if (op_s1 == cau_pkg::OP_DIV) begin
				t_re_s2 <= rr_x + ii_x;
				t_im_s2 <= ir_x - ri_x;
			end else begin
				t_re_s2 <= rr_x - ii_x;
				t_im_s2 <= ri_x + ir_x;
			end
		end
	end

	function automatic logic [MW-1:0] mag_of(input logic signed [PW:0] t);
		logic [PW:0] n;
		n = t[PW] ? $unsigned(-t) : $unsigned(t);
		return n[MW-1:0];
	endfunction

	// multiply rounding: ties away from zero, then clamp
	function automatic logic [W:0] mul_fix(input logic [MW-1:0] mag, input logic neg);
		logic [MW+1:0] r;
		logic [MW-1:0] qm;
		logic          sat;
		logic [W-1:0]  v;
		r   = ({1'b0, mag, 1'b0} + ({{(MW + 1){1'b0}}, 1'b1} << FRAC_BITS)) >> (FRAC_BITS + 1);
		qm  = r[MW-1:0];
		sat = neg ? (qm > LIM_M) : (qm > HI_M);
		if (sat) v = neg ? MINV : MAXV;
		else     v = neg ? (-qm[W-1:0]) : qm[W-1:0];
		return {sat, v};
	endfunction

	function automatic logic [W:0] sum_fix(input logic signed [W:0] s);
		logic sat;
		sat = s[W] ^ s[W-1];
		return {sat, sat ? (s[W] ? MINV : MAXV) : s[W-1:0]};
	endfunction

	logic [MW-1:0]        mag_re, mag_im;
	logic [W:0]           mfix_re, mfix_im, sfix_re, sfix_im;
	logic [REM_WIDTH-1:0] n_re, n_im, dd, dd_top;
	assign mag_re  = mag_of(t_re_s2);
	assign mag_im  = mag_of(t_im_s2);
	assign mfix_re = mul_fix(mag_re, t_re_s2[PW]);
	assign mfix_im = mul_fix(mag_im, t_im_s2[PW]);
	assign sfix_re = sum_fix(sum_re_s2);
	assign sfix_im = sum_fix(sum_im_s2);
	assign dd      = REM_WIDTH'(den_s2) << 1;
	assign dd_top  = dd << W;
	assign n_re    = (REM_WIDTH'(mag_re) << (FRAC_BITS + 1)) + REM_WIDTH'(den_s2);
	assign n_im    = (REM_WIDTH'(mag_im) << (FRAC_BITS + 1)) + REM_WIDTH'(den_s2);

	always_ff @(posedge clk) begin
		if (rdy3 && v_s2) begin
			out_flags.is_div   <= (op_s2 == cau_pkg::OP_DIV);
			out_flags.div_zero <= (op_s2 == cau_pkg::OP_DIV) && bz_s2;
			out_flags.neg_re   <= t_re_s2[PW];
			out_flags.neg_im   <= t_im_s2[PW];
			out_flags.ovf_re   <= (n_re >= dd_top);
			out_flags.ovf_im   <= (n_im >= dd_top);
			out_rem_re         <= n_re;
			out_rem_im         <= n_im;
			out_dd             <= dd;
			if (op_s2 == cau_pkg::OP_MUL) begin
				out_val_re        <= $signed(mfix_re[W-1:0]);
				out_val_im        <= $signed(mfix_im[W-1:0]);
				out_flags.val_sat <= mfix_re[W] | mfix_im[W];
			end else begin
				out_val_re        <= $signed(sfix_re[W-1:0]);
				out_val_im        <= $signed(sfix_im[W-1:0]);
				out_flags.val_sat <= sfix_re[W] | sfix_im[W];
			end
		end
	end
endmodule

FILE: rtl/cau_div_stage.sv
// One restoring-division step: decides quotient bit BIT for both parts.
module cau_div_stage #(
	parameter int DATA_WIDTH = cau_pkg::DATA_WIDTH_DEF,
	parameter int REM_WIDTH  = 3 * DATA_WIDTH + 2,
	parameter int BIT        = 0
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  cau_pkg::cau_flags_t          in_flags,
	input  logic signed [DATA_WIDTH-1:0] in_val_re,
	input  logic signed [DATA_WIDTH-1:0] in_val_im,
	input  logic [REM_WIDTH-1:0]         in_rem_re,
	input  logic [REM_WIDTH-1:0]         in_rem_im,
	input  logic [REM_WIDTH-1:0]         in_dd,
	input  logic [DATA_WIDTH-1:0]        in_q_re,
	input  logic [DATA_WIDTH-1:0]        in_q_im,
	output logic                         out_valid,
	input  logic                         out_ready,
	output cau_pkg::cau_flags_t          out_flags,
	output logic signed [DATA_WIDTH-1:0] out_val_re,
	output logic signed [DATA_WIDTH-1:0] out_val_im,
	output logic [REM_WIDTH-1:0]         out_rem_re,
	output logic [REM_WIDTH-1:0]         out_rem_im,
	output logic [REM_WIDTH-1:0]         out_dd,
	output logic [DATA_WIDTH-1:0]        out_q_re,
	output logic [DATA_WIDTH-1:0]        out_q_im
);
	logic valid_s1;

	assign in_ready  = !valid_s1 || out_ready;
	assign out_valid = valid_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) valid_s1 <= 1'b0;
		else if (in_ready) valid_s1 <= in_valid;
	end

	logic [REM_WIDTH-1:0]  shifted;
	logic                  ge_re, ge_im;
	logic [DATA_WIDTH-1:0] q_re_nxt, q_im_nxt;

	assign shifted = in_dd << BIT;
	assign ge_re   = in_rem_re >= shifted;
	assign ge_im   = in_rem_im >= shifted;

	always_comb begin
		q_re_nxt      = in_q_re;
		q_im_nxt      = in_q_im;
		q_re_nxt[BIT] = ge_re;
		q_im_nxt[BIT] = ge_im;
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			out_flags  <= in_flags;
			out_val_re <= in_val_re;
			out_val_im <= in_val_im;
			out_dd     <= in_dd;
			out_rem_re <= ge_re ? in_rem_re - shifted : in_rem_re;
			out_rem_im <= ge_im ? in_rem_im - shifted : in_rem_im;
			out_q_re   <= q_re_nxt;
			out_q_im   <= q_im_nxt;
		end
	end
endmodule

FILE: rtl/cau_back.sv
// Output stage: quotient sign and clamp, status, result register.
`include "complex_arithmetic_unit_defines.svh"
module cau_back #(
	parameter int DATA_WIDTH = cau_pkg::DATA_WIDTH_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  cau_pkg::cau_flags_t          in_flags,
	input  logic signed [DATA_WIDTH-1:0] in_val_re,
	input  logic signed [DATA_WIDTH-1:0] in_val_im,
	input  logic [DATA_WIDTH-1:0]        in_q_re,
	input  logic [DATA_WIDTH-1:0]        in_q_im,
	cau_res_if.source                    res
);
	localparam int W = DATA_WIDTH;
	localparam logic [W-1:0] MAXV = {1'b0, {(W - 1){1'b1}}};
	localparam logic [W-1:0] MINV = {1'b1, {(W - 1){1'b0}}};

	logic valid_q;

	assign in_ready  = !valid_q || res.ready;
	assign res.valid = valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) valid_q <= 1'b0;
		else if (in_ready) valid_q <= in_valid;
	end

	function automatic logic [W:0] div_fix(input logic [W-1:0] q, input logic neg,
		input logic ovf);
		logic sat;
		sat = neg ? (ovf | (q[W-1] & (|q[W-2:0]))) : (ovf | q[W-1]);
		if (sat) return {1'b1, neg ? MINV : MAXV};
		return {1'b0, neg ? -q : q};
	endfunction

	logic [W:0]   dfix_re, dfix_im;
	logic [W-1:0] re_nxt, im_nxt;
	logic [1:0]   st_nxt;

	assign dfix_re = div_fix(in_q_re, in_flags.neg_re, in_flags.ovf_re);
	assign dfix_im = div_fix(in_q_im, in_flags.neg_im, in_flags.ovf_im);

	always_comb begin
		priority if (in_flags.div_zero) begin
			re_nxt = '0;
			im_nxt = '0;
			st_nxt = cau_pkg::ST_DIVZERO;
		end else if (in_flags.is_div) begin
			re_nxt = dfix_re[W-1:0];
			im_nxt = dfix_im[W-1:0];
			st_nxt = (dfix_re[W] | dfix_im[W]) ? cau_pkg::ST_SAT : cau_pkg::ST_OK;
		end else begin
			re_nxt = in_val_re;
			im_nxt = in_val_im;
			st_nxt = in_flags.val_sat ? cau_pkg::ST_SAT : cau_pkg::ST_OK;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			res.res_re <= $signed(re_nxt);
			res.res_im <= $signed(im_nxt);
			res.status <= st_nxt;
		end
	end

	`CAU_ASSERT_IMPL(a_divz_zero, clk, arst_n, res.valid && res.status == cau_pkg::ST_DIVZERO, res.res_re == '0 && res.res_im == '0, "divide by zero with nonzero result")
	`CAU_ASSERT_IMPL(a_status_code, clk, arst_n, res.valid, res.status == cau_pkg::ST_OK || res.status == cau_pkg::ST_DIVZERO || res.status == cau_pkg::ST_SAT, "undefined status code")
	`CAU_ASSERT_NEXT(a_load, clk, arst_n, in_valid && in_ready, res.valid, "request lost at output register")
endmodule

FILE: rtl/complex_arithmetic_unit.sv
// Throughput: one request per cycle unless res.ready stalls the pipe; the
// restoring divider is unrolled into one register stage per quotient bit, so
// every operation takes the same pipe.
// Reset (arst_n low, asynchronous) clears only the stage valid bits; data
// registers are not reset. No state links requests.
module complex_arithmetic_unit #(
	parameter int DATA_WIDTH = cau_pkg::DATA_WIDTH_DEF,
	parameter int FRAC_BITS  = cau_pkg::FRAC_BITS_DEF
) (
	input logic       clk,
	input logic       arst_n,
	cau_req_if.sink   req,
	cau_res_if.source res
);
	// Remainder width covers (2*|num| << FRAC_BITS) + den and 2*den << DATA_WIDTH.
	localparam int W  = DATA_WIDTH;
	localparam int RW = 3 * DATA_WIDTH + FRAC_BITS + 2;

	// Pipe taps: index 0 leaves the front end, index W enters the output stage.
	logic                v    [0:W];
	logic                rdy  [0:W];
	cau_pkg::cau_flags_t fl   [0:W];
	logic signed [W-1:0] vre  [0:W];
	logic signed [W-1:0] vim  [0:W];
	logic [RW-1:0]       rre  [0:W];
	logic [RW-1:0]       rim  [0:W];
	logic [RW-1:0]       dd   [0:W];
	logic [W-1:0]        qre  [0:W];
	logic [W-1:0]        qim  [0:W];

	// Stages 1-3: six products, sums, rounding of add/sub/mul results, and
	// the dividend/divisor setup with the early quotient-overflow check.
	cau_front #(
		.DATA_WIDTH(DATA_WIDTH),
		.FRAC_BITS (FRAC_BITS),
		.REM_WIDTH (RW)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req),
		.out_valid (v[0]),
		.out_ready (rdy[0]),
		.out_flags (fl[0]),
		.out_val_re(vre[0]),
		.out_val_im(vim[0]),
		.out_rem_re(rre[0]),
		.out_rem_im(rim[0]),
		.out_dd    (dd[0])
	);

	assign qre[0] = '0;
	assign qim[0] = '0;

	// One quotient bit per stage, MSB first. Non-divide requests ride along.
	for (genvar j = 0; j < W; j++) begin : g_div
		cau_div_stage #(
			.DATA_WIDTH(DATA_WIDTH),
			.REM_WIDTH (RW),
			.BIT       (W - 1 - j)
		) u_stage (
			.clk       (clk),
			.arst_n    (arst_n),
			.in_valid  (v[j]),
			.in_ready  (rdy[j]),
			.in_flags  (fl[j]),
			.in_val_re (vre[j]),
			.in_val_im (vim[j]),
			.in_rem_re (rre[j]),
			.in_rem_im (rim[j]),
			.in_dd     (dd[j]),
			.in_q_re   (qre[j]),
			.in_q_im   (qim[j]),
			.out_valid (v[j+1]),
			.out_ready (rdy[j+1]),
			.out_flags (fl[j+1]),
			.out_val_re(vre[j+1]),
			.out_val_im(vim[j+1]),
			.out_rem_re(rre[j+1]),
			.out_rem_im(rim[j+1]),
			.out_dd    (dd[j+1]),
			.out_q_re  (qre[j+1]),
			.out_q_im  (qim[j+1])
		);
	end

	// Final stage: quotient sign and saturation, status, output register.
	cau_back #(
		.DATA_WIDTH(DATA_WIDTH)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (v[W]),
		.in_ready (rdy[W]),
		.in_flags (fl[W]),
		.in_val_re(vre[W]),
		.in_val_im(vim[W]),
		.in_q_re  (qre[W]),
		.in_q_im  (qim[W]),
		.res      (res)
	);
endmodule

FILE: tb/complex_arithmetic_unit_tb.sv
`timescale 1ns / 1ps

module complex_arithmetic_unit_tb;

	localparam int DW = 16;
	localparam int FB = 8;
	localparam int LATENCY = DW + 4;
	localparam longint CYCLE_LIMIT = 400000;

	typedef struct packed {
		logic signed [DW-1:0] re;
		logic signed [DW-1:0] im;
		logic [1:0]           status;
	} cplx_result_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	cau_req_if #(.DATA_WIDTH(DW)) req_ch ();
	cau_res_if #(.DATA_WIDTH(DW)) res_ch ();

	complex_arithmetic_unit #(.DATA_WIDTH(DW), .FRAC_BITS(FB)) dut (
		.clk(clk),
		.arst_n(arst_n),
		.req(req_ch.sink),
		.res(res_ch.source)
	);

	// expected results, oldest first
	cplx_result_t expected_q[$];
	int mismatch_count = 0;
	int result_count = 0;
	int request_count = 0;
	int send_idle_pct = 0;
	int recv_stall_pct = 0;
	longint cycle_count = 0;
	int op_seen[4] = '{0, 0, 0, 0};
	int divzero_seen = 0;
	int sat_seen = 0;

	initial begin
		forever #2 clk = ~clk;
	end

	// run guard
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("Timeout after %0d cycles", cycle_count);
			$display("Mismatches found");
			$finish;
		end
	end

	// round to nearest, ties away from zero; den > 0
	function automatic longint round_div(longint num, longint den);
		longint mag;
		longint q;
		mag = (num < 0) ? -num : num;
		q = (2 * mag + den) / (2 * den);
		return (num < 0) ? -q : q;
	endfunction

	function automatic longint clamp_part(longint v, ref bit sat);
		longint hi;
		longint lo;
		hi = (longint'(1) <<< (DW - 1)) - 1;
		lo = -hi - 1;
		if (v > hi) begin
			sat = 1'b1;
			return hi;
		end
		if (v < lo) begin
			sat = 1'b1;
			return lo;
		end
		return v;
	endfunction

	function automatic cplx_result_t complex_alu_result(cau_pkg::cau_op_t op,
			logic signed [DW-1:0] ar_i, logic signed [DW-1:0] ai_i,
			logic signed [DW-1:0] br_i, logic signed [DW-1:0] bi_i);
		longint ar, ai, br, bi, re, im, den, scale;
		bit sat;
		cplx_result_t r;
		ar = longint'(ar_i);
		ai = longint'(ai_i);
		br = longint'(br_i);
		bi = longint'(bi_i);
		scale = longint'(1) <<< FB;
		re = 0;
		im = 0;
		sat = 1'b0;
		r.status = cau_pkg::ST_OK;
		case (op)
			cau_pkg::OP_ADD: begin
				re = ar + br;
				im = ai + bi;
			end
			cau_pkg::OP_SUB: begin
				re = ar - br;
				im = ai - bi;
			end
			cau_pkg::OP_MUL: begin
				re = round_div(ar * br - ai * bi, scale);
				im = round_div(ar * bi + ai * br, scale);
			end
			default: begin
				if (br == 0 && bi == 0) begin
					r.status = cau_pkg::ST_DIVZERO;
				end else begin
					den = br * br + bi * bi;
					re = round_div((ar * br + ai * bi) * scale, den);
					im = round_div((ai * br - ar * bi) * scale, den);
				end
			end
		endcase
		if (r.status == cau_pkg::ST_OK) begin
			re = clamp_part(re, sat);
			im = clamp_part(im, sat);
			if (sat)
				r.status = cau_pkg::ST_SAT;
		end
		r.re = re[DW-1:0];
		r.im = im[DW-1:0];
		return r;
	endfunction

	// sends one request; prediction is queued at acceptance
	task automatic send_request(cau_pkg::cau_op_t op, logic signed [DW-1:0] ar,
			logic signed [DW-1:0] ai, logic signed [DW-1:0] br,
			logic signed [DW-1:0] bi);
		cplx_result_t r;
		while ($urandom_range(99) < send_idle_pct) begin
			req_ch.valid <= 1'b0;
			@(posedge clk);
		end
		req_ch.valid    <= 1'b1;
		req_ch.req_type <= op;
		req_ch.a_re     <= ar;
		req_ch.a_im     <= ai;
		req_ch.b_re     <= br;
		req_ch.b_im     <= bi;
		do
			@(posedge clk);
		while (!req_ch.ready);
		r = complex_alu_result(op, ar, ai, br, bi);
		expected_q.push_back(r);
		request_count++;
		op_seen[op]++;
		if (r.status == cau_pkg::ST_DIVZERO)
			divzero_seen++;
		if (r.status == cau_pkg::ST_SAT)
			sat_seen++;
	endtask

	// one idle cycle on the request side
	task automatic release_valid();
		req_ch.valid <= 1'b0;
		@(posedge clk);
	endtask

	// result checker; ready randomized each edge
	always @(posedge clk) begin
		if (arst_n && res_ch.valid && res_ch.ready) begin
			cplx_result_t exp_r;
			if (expected_q.size() == 0) begin
				mismatch_count++;
				if (mismatch_count <= 10)
					$display("Unexpected result re=%0d im=%0d status=%0d",
						res_ch.res_re, res_ch.res_im, res_ch.status);
			end else begin
				exp_r = expected_q.pop_front();
				result_count++;
				if (exp_r.re !== res_ch.res_re || exp_r.im !== res_ch.res_im
						|| exp_r.status !== res_ch.status) begin
					mismatch_count++;
					if (mismatch_count <= 10)
						$display("Result %0d: expected re=%0d im=%0d status=%0d, got re=%0d im=%0d status=%0d",
							result_count, exp_r.re, exp_r.im, exp_r.status,
							res_ch.res_re, res_ch.res_im, res_ch.status);
				end
			end
		end
		res_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
	end

	function automatic logic signed [DW-1:0] corner_value();
		case ($urandom_range(7))
			0: return 16'sh7FFF;
			1: return 16'sh8000;
			2: return 16'sh0000;
			3: return 16'sh0100;
			4: return 16'shFF00;
			5: return 16'sh0001;
			6: return 16'shFFFF;
			default: return 16'(signed'($urandom_range(65535)));
		endcase
	endfunction

	// small values keep results mostly in range; a quarter uses full range
	function automatic logic signed [DW-1:0] operand_value();
		case ($urandom_range(3))
			0: return 16'(signed'($urandom_range(65535)));
			1: return corner_value();
			default: return 16'($signed($urandom_range(4095)) - 2048);
		endcase
	endfunction

	task automatic test_directed();
		send_request(cau_pkg::OP_ADD, 16'sh7FFF, 16'sh8000, 16'sh7FFF, 16'sh8000);
		send_request(cau_pkg::OP_ADD, 16'sh0100, 16'shFF00, 16'sh0080, 16'sh0040);
		send_request(cau_pkg::OP_SUB, 16'sh8000, 16'sh7FFF, 16'sh0001, 16'shFFFF);
		send_request(cau_pkg::OP_SUB, 16'sh0000, 16'sh0000, 16'sh8000, 16'sh8000);
		send_request(cau_pkg::OP_MUL, 16'sh0100, 16'sh0000, 16'sh0100, 16'sh0000);
		send_request(cau_pkg::OP_MUL, 16'sh0000, 16'sh0100, 16'sh0000, 16'sh0100);
		send_request(cau_pkg::OP_MUL, 16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000);
		send_request(cau_pkg::OP_MUL, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 16'sh8000);
		send_request(cau_pkg::OP_MUL, 16'sh0001, 16'sh0000, 16'sh0080, 16'sh0000); // tie
		send_request(cau_pkg::OP_MUL, 16'shFFFF, 16'sh0000, 16'sh0080, 16'sh0000); // neg tie
		send_request(cau_pkg::OP_MUL, 16'sh0000, 16'sh1234, 16'sh0000, 16'sh0000); // zero B
		send_request(cau_pkg::OP_DIV, 16'sh1234, 16'sh4321, 16'sh0000, 16'sh0000); // div zero
		send_request(cau_pkg::OP_DIV, 16'sh0100, 16'sh0000, 16'sh0100, 16'sh0000);
		send_request(cau_pkg::OP_DIV, 16'sh0100, 16'sh0100, 16'sh0000, 16'sh0100);
		send_request(cau_pkg::OP_DIV, 16'sh7FFF, 16'sh7FFF, 16'sh0001, 16'sh0000);
		send_request(cau_pkg::OP_DIV, 16'sh8000, 16'sh8000, 16'sh0001, 16'sh0001);
		send_request(cau_pkg::OP_DIV, 16'sh0001, 16'sh0000, 16'sh8000, 16'sh8000);
		send_request(cau_pkg::OP_DIV, 16'sh0100, 16'sh0000, 16'sh0300, 16'sh0000); // 1/3
		send_request(cau_pkg::OP_DIV, 16'sh7FFF, 16'sh8000, 16'sh7FFF, 16'sh7FFF);
		send_request(cau_pkg::OP_ADD, 16'sh0000, 16'sh0000, 16'sh0000, 16'sh0000);
		release_valid();
	endtask

	task automatic test_random(int count);
		for (int i = 0; i < count; i++) begin
			cau_pkg::cau_op_t op;
			logic signed [DW-1:0] br, bi;
			op = cau_pkg::cau_op_t'($urandom_range(3));
			br = operand_value();
			bi = operand_value();
			if ($urandom_range(19) == 0) begin
				br = '0;
				bi = '0;
			end
			send_request(op, operand_value(), operand_value(), br, bi);
			if ($urandom_range(9) == 0)
				release_valid();
		end
		release_valid();
	endtask

	task automatic drain_results();
		while (expected_q.size() != 0)
			@(posedge clk);
		repeat (LATENCY + 5) @(posedge clk);
	endtask

	initial begin
		req_ch.valid    = 1'b0;
		req_ch.req_type = cau_pkg::OP_ADD;
		req_ch.a_re     = '0;
		req_ch.a_im     = '0;
		req_ch.b_re     = '0;
		req_ch.b_im     = '0;
		res_ch.ready    = 1'b0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_idle_pct = 29;
		recv_stall_pct = 76;
		test_directed();
		test_random(280);
		drain_results();

		send_idle_pct = 76;
		recv_stall_pct = 29;
		test_random(280);
		drain_results();

		send_idle_pct = 0;
		recv_stall_pct = 0;
		test_random(290);
		drain_results();

		$display("Covered %0d requests: add %0d, sub %0d, mul %0d, div %0d",
			request_count, op_seen[0], op_seen[1], op_seen[2], op_seen[3]);
		$display("Divide-by-zero cases %0d, saturated results %0d, errors %0d",
			divzero_seen, sat_seen, mismatch_count);
		if (mismatch_count == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule
